// ===== hw/rtl/fdss_pkg.sv =====
// ----------------------------------------------------------------------------
// fdss_pkg: shared types and constants of the four digit scanner
// Field widths, divider reciprocals, pipeline stage records and the
// seven-segment decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdss_pkg;

  // Field widths
  localparam int ValueWidth   = 32;
  localparam int DwellCfgW    = 16;
  localparam int SegWidth     = 8;
  localparam int NumDigits    = 4;
  localparam int DigitWidth   = 4;
  localparam int PosWidth     = $clog2(NumDigits);
  localparam int RemWidth     = 14;

  // Dwell counter width and compare width
  localparam int DwellWidth   = 16;
  localparam int CmpWidth     = (DwellWidth + 1 > DwellCfgW) ? DwellWidth + 1 : DwellCfgW;

  // Reset value of the dwell register
  localparam logic [DwellCfgW-1:0] DwellReset = DwellCfgW'(2);

  // Reduction modulo 10000: quotient = (value * RecipMod) >> RecipShift
  localparam int                    Modulus    = 10000;
  localparam logic [ValueWidth-1:0] RecipMod   = 32'hD1B7_1759;
  localparam int                    RecipShift = 45;
  localparam int                    QuotWidth  = 19;

  // Digit split of a value below 10000
  localparam int ProdWidth  = 2 * RemWidth;
  localparam int Recip1000  = 8389;
  localparam int Shift1000  = 23;
  localparam int Recip100   = 10486;
  localparam int Shift100   = 20;
  localparam int Recip10    = 13108;
  localparam int Shift10    = 17;
  localparam int HundW      = 7;
  localparam int TenW       = 10;

  localparam logic [NumDigits-1:0] AllOff = '1;

  typedef enum logic {
    ActLoad = 1'b0,
    ActTick = 1'b1
  } action_e;

  typedef logic [DigitWidth-1:0]                digit_t;
  typedef logic [NumDigits-1:0][DigitWidth-1:0] digit_vec_t;

  // Remainder stage record
  typedef struct packed {
    logic                valid;
    logic                action;
    logic [RemWidth-1:0] rem;
  } rem_stage_t;

  // Digit stage record, index 0 is the thousands
  typedef struct packed {
    logic       valid;
    logic       action;
    digit_vec_t digits;
  } digit_stage_t;

  // Segment pattern a..g, decimal point off
  function automatic logic [SegWidth-1:0] seg_decode(input digit_t d);
    logic [SegWidth-1:0] seg;
    case (d)
      4'd0:    seg = 8'hfc;
      4'd1:    seg = 8'h60;
      4'd2:    seg = 8'hda;
      4'd3:    seg = 8'hf2;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'hb6;
      4'd6:    seg = 8'hbe;
      4'd7:    seg = 8'he0;
      4'd8:    seg = 8'hfe;
      4'd9:    seg = 8'hf6;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fdss_in_if.sv =====
// ----------------------------------------------------------------------------
// fdss_in_if: input channel of the scanner
// Valid/ready channel carrying the action and the value to show.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fdss_in_if;
  import fdss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [ValueWidth-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fdss_out_if.sv =====
// ----------------------------------------------------------------------------
// fdss_out_if: output channel of the scanner
// Valid/ready channel carrying the segment drive and digit enables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fdss_out_if;
  import fdss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SegWidth-1:0]  segments;
  logic [NumDigits-1:0] digit_enables;

  modport source (output valid, output segments, output digit_enables, input ready);
  modport sink   (input valid, input segments, input digit_enables, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/four_digit_seven_segment_scanner.sv =====
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner: multiplexed four digit display driver
// Path: s1..s3 reduce, s4 and s5 split the digits, then the result register.
// Throughput: one item per cycle; a waiting result stalls the whole
// pipeline as one, set by the single shared advance enable.
// Reset: all digits off, digits zero, scan at the leftmost digit, dwell 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module four_digit_seven_segment_scanner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fdss_pkg::DwellCfgW-1:0] cfg_wdata_i,
  fdss_in_if.sink                        in_i,
  fdss_out_if.source                     out_o
);
  import fdss_pkg::*;

  logic [DwellCfgW-1:0] dwell_q;
  logic                 advance;
  rem_stage_t           rem_stage;
  digit_stage_t         dig_stage;

  // Hold the dwell setting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_q <= DwellReset;
    end else if (cfg_we_i) begin
      dwell_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = advance;

  fdss_mod10k u_mod10k (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .valid_i  (in_i.valid),
    .action_i (in_i.action),
    .value_i  (in_i.value),
    .rem_o    (rem_stage)
  );

  fdss_digits u_digits (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .rem_i  (rem_stage),
    .dig_o  (dig_stage)
  );

  fdss_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dig_i   (dig_stage),
    .dwell_i (dwell_q),
    .en_o    (advance),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fdss_mod10k.sv =====
// ----------------------------------------------------------------------------
// fdss_mod10k: input register and reduction modulo 10000
// Registers the transfer, multiplies by the reciprocal of 10000, then
// subtracts the quotient times 10000 to leave the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdss_mod10k (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic                            action_i,
  input  logic [fdss_pkg::ValueWidth-1:0] value_i,
  output fdss_pkg::rem_stage_t            rem_o
);
  import fdss_pkg::*;

  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic                    s1_action_q, s2_action_q, s3_action_q;
  logic [ValueWidth-1:0]   s1_value_q, s2_value_q;
  logic [QuotWidth-1:0]    s2_quot_q;
  logic [RemWidth-1:0]     s3_rem_q;
  logic [2*ValueWidth-1:0] quot_prod;
  logic [QuotWidth-1:0]    quot_d;
  logic [ValueWidth-1:0]   quot_scaled;
  logic [RemWidth-1:0]     rem_d;

  // Quotient by reciprocal multiplication
  assign quot_prod = (2*ValueWidth)'(s1_value_q) * (2*ValueWidth)'(RecipMod);
  assign quot_d    = quot_prod[RecipShift +: QuotWidth];

  // Remainder: only the low bits matter since it stays below 10000
  assign quot_scaled = ValueWidth'(s2_quot_q) * ValueWidth'(Modulus);
  assign rem_d       = RemWidth'(s2_value_q - quot_scaled);

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_action_q <= action_i;
      s1_value_q  <= value_i;
      s2_action_q <= s1_action_q;
      s2_value_q  <= s1_value_q;
      s2_quot_q   <= quot_d;
      s3_action_q <= s2_action_q;
      s3_rem_q    <= rem_d;
    end
  end

  assign rem_o.valid  = s3_valid_q;
  assign rem_o.action = s3_action_q;
  assign rem_o.rem    = s3_rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fdss_digits.sv =====
// ----------------------------------------------------------------------------
// fdss_digits: decimal split of the remainder
// Takes quotients by 1000, 100 and 10 through reciprocals, then strips
// the higher part of each to leave four decimal digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdss_digits (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  fdss_pkg::rem_stage_t    rem_i,
  output fdss_pkg::digit_stage_t  dig_o
);
  import fdss_pkg::*;

  logic                 s4_valid_q, s5_valid_q;
  logic                 s4_action_q, s5_action_q;
  digit_t               s4_thou_q;
  logic [HundW-1:0]     s4_hund_q;
  logic [TenW-1:0]      s4_ten_q;
  logic [RemWidth-1:0]  s4_rem_q;
  digit_vec_t           s5_digits_q;
  logic [ProdWidth-1:0] prod_1000, prod_100, prod_10;
  digit_vec_t           digits_d;

  // Quotients by 1000, 100 and 10
  assign prod_1000 = ProdWidth'(rem_i.rem) * ProdWidth'(Recip1000);
  assign prod_100  = ProdWidth'(rem_i.rem) * ProdWidth'(Recip100);
  assign prod_10   = ProdWidth'(rem_i.rem) * ProdWidth'(Recip10);

  // Strip the higher part: times ten is a shift and add
  assign digits_d[0] = s4_thou_q;
  assign digits_d[1] = DigitWidth'(s4_hund_q - HundW'(s4_thou_q) * HundW'(10));
  assign digits_d[2] = DigitWidth'(s4_ten_q - TenW'(s4_hund_q) * TenW'(10));
  assign digits_d[3] = DigitWidth'(s4_rem_q - RemWidth'(s4_ten_q) * RemWidth'(10));

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en_i) begin
      s4_valid_q <= rem_i.valid;
      s5_valid_q <= s4_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_action_q <= rem_i.action;
      s4_thou_q   <= prod_1000[Shift1000 +: DigitWidth];
      s4_hund_q   <= prod_100[Shift100 +: HundW];
      s4_ten_q    <= prod_10[Shift10 +: TenW];
      s4_rem_q    <= rem_i.rem;
      s5_action_q <= s4_action_q;
      s5_digits_q <= digits_d;
    end
  end

  assign dig_o.valid  = s5_valid_q;
  assign dig_o.action = s5_action_q;
  assign dig_o.digits = s5_digits_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fdss_scan.sv =====
// ----------------------------------------------------------------------------
// fdss_scan: scan state and result register
// Holds the shown digits, scan position and dwell counter, updates them
// once per transfer and registers the segment drive of the lit digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdss_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fdss_pkg::digit_stage_t         dig_i,
  input  logic [fdss_pkg::DwellCfgW-1:0] dwell_i,
  output logic                           en_o,
  fdss_out_if.source                     out_o
);
  import fdss_pkg::*;

  logic                  valid_q;
  logic [SegWidth-1:0]   seg_q, seg_d;
  logic [NumDigits-1:0]  enables_q, enables_d;
  logic                  on_q, on_d;
  logic [PosWidth-1:0]   pos_q, pos_d;
  logic [DwellWidth-1:0] cnt_q, cnt_d;
  digit_vec_t            digits_q, digits_d;
  logic [DwellWidth:0]   cnt_next;
  logic                  wrap;

  // Advance the whole pipeline unless a result waits
  assign en_o = !valid_q || out_o.ready;

  assign cnt_next = {1'b0, cnt_q} + (DwellWidth+1)'(1);
  assign wrap     = (CmpWidth'(cnt_next) >= CmpWidth'(dwell_i)) || cnt_next[DwellWidth];

  // Next scan state and result
  always_comb begin
    on_d     = on_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    digits_d = digits_q;
    if (en_o && dig_i.valid) begin
      if (dig_i.action == ActLoad) begin
        on_d     = 1'b1;
        pos_d    = '0;
        cnt_d    = '0;
        digits_d = dig_i.digits;
      end else if (on_q) begin
        if (wrap) begin
          cnt_d = '0;
          pos_d = pos_q + PosWidth'(1);
        end else begin
          cnt_d = cnt_next[DwellWidth-1:0];
        end
      end
    end
    if (on_d) begin
      seg_d     = seg_decode(digits_d[pos_d]);
      enables_d = ~(NumDigits'(1) << pos_d);
    end else begin
      seg_d     = '0;
      enables_d = AllOff;
    end
  end

  // Hold the scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      on_q     <= 1'b0;
      pos_q    <= '0;
      cnt_q    <= '0;
      digits_q <= '0;
    end else begin
      if (en_o) begin
        valid_q <= dig_i.valid;
      end
      on_q     <= on_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      digits_q <= digits_d;
    end
  end

  // Register the result
  always_ff @(posedge clk_i) begin
    if (en_o && dig_i.valid) begin
      seg_q     <= seg_d;
      enables_q <= enables_d;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.segments      = seg_q;
  assign out_o.digit_enables = enables_q;

endmodule

`default_nettype wire
